@@ rtl/core/mwd_pkg.sv @@
`timescale 1ns / 1ps

package mwd_pkg;

   localparam int MAG_W     = 16;
   localparam int ONE_G_W   = 15;
   localparam int UG_W      = 24;
   localparam int TICK_W    = 16;
   localparam int BAND_W    = 20;
   localparam int CSR_IDX_W = 2;

   // half = one_g * ug / 1000000, done as ((one_g * ug) >> 6) / 15625
   // with a reciprocal multiply that is exact for a 33-bit dividend.
   localparam int PROD_W      = ONE_G_W + UG_W;
   localparam int PRE_SHIFT   = 6;
   localparam int SPLIT_W     = 17;
   localparam int RECIP_W     = 34;
   localparam int RECIP_SHIFT = 47;
   localparam int XH_W        = PROD_W - PRE_SHIFT - SPLIT_W;
   localparam int PP_HI_W     = XH_W + RECIP_W;
   localparam int PP_LO_W     = SPLIT_W + RECIP_W;
   localparam int SUM_W       = PP_HI_W + SPLIT_W + 1;
   localparam logic [RECIP_W-1:0] UG_RECIP = 34'd9007199255;

   localparam logic [UG_W-1:0]   INITIAL_UG_RST  = 24'd100000;
   localparam logic [UG_W-1:0]   CONTINUE_UG_RST = 24'd50000;
   localparam logic [TICK_W-1:0] HOLD_TICKS_RST  = 16'd60;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_INITIAL_UG  = 2'd0,
      CSR_CONTINUE_UG = 2'd1,
      CSR_HOLD_TICKS  = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_TICK   = 1'b1
   } op_type;

   typedef struct packed {
      op_type               op;
      logic [MAG_W-1:0]     magnitude;
      logic [ONE_G_W-1:0]   one_g;
      logic                 last;
   } item_type;

   typedef struct packed {
      logic [ONE_G_W-1:0] lo;
      logic [BAND_W-1:0]  hi;
   } band_type;

   typedef struct packed {
      band_type init;
      band_type cont;
   } band_pair_type;

endpackage

@@ rtl/core/mwd_if.sv @@
`timescale 1ns / 1ps

interface mwd_req_if;
   import mwd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 op;
   logic [MAG_W-1:0]     magnitude;
   logic [ONE_G_W-1:0]   one_g_count;
   logic                 last_in_batch;

   modport source (output valid, output op, output magnitude, output one_g_count,
                   output last_in_batch, input ready);
   modport sink (input valid, input op, input magnitude, input one_g_count,
                 input last_in_batch, output ready);
endinterface

interface mwd_rsp_if;
   logic valid;
   logic ready;
   logic moving;
   logic started_moving;
   logic out_of_band;

   modport source (output valid, output moving, output started_moving,
                   output out_of_band, input ready);
   modport sink (input valid, input moving, input started_moving,
                 input out_of_band, output ready);
endinterface

@@ rtl/core/mwd_band_calc.sv @@
`timescale 1ns / 1ps

module mwd_band_calc (
   input  logic                          clock,
   input  logic [3:0]                    stage_en,
   input  logic [mwd_pkg::UG_W-1:0]      threshold_ug,
   input  logic [mwd_pkg::ONE_G_W-1:0]   one_g_s0,
   input  logic [mwd_pkg::ONE_G_W-1:0]   one_g_s3,
   output mwd_pkg::band_type             band
);
   import mwd_pkg::*;

   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [PP_HI_W-1:0] pp_hi_ff, pp_hi_in;
   logic [PP_LO_W-1:0] pp_lo_ff, pp_lo_in;
   logic [SUM_W-1:0]   sum;
   logic [BAND_W-1:0]  half_ff, half_in;
   band_type           band_ff, band_in;

   always_comb begin
      prod_in  = PROD_W'(one_g_s0) * PROD_W'(threshold_ug);
      // split the pre-shifted dividend so each product stays narrow
      pp_hi_in = PP_HI_W'(prod_ff[PROD_W-1:PRE_SHIFT+SPLIT_W]) * PP_HI_W'(UG_RECIP);
      pp_lo_in = PP_LO_W'(prod_ff[PRE_SHIFT+SPLIT_W-1:PRE_SHIFT]) * PP_LO_W'(UG_RECIP);
      sum      = SUM_W'({pp_hi_ff, {SPLIT_W{1'b0}}}) + SUM_W'(pp_lo_ff);
      half_in  = sum[RECIP_SHIFT+BAND_W-1:RECIP_SHIFT];
      band_in.hi = BAND_W'(one_g_s3) + half_ff;
      if (half_ff < BAND_W'(one_g_s3)) begin
         band_in.lo = ONE_G_W'(BAND_W'(one_g_s3) - half_ff);
      end else begin
         band_in.lo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         prod_ff <= prod_in;
      end
      if (stage_en[1]) begin
         pp_hi_ff <= pp_hi_in;
         pp_lo_ff <= pp_lo_in;
      end
      if (stage_en[2]) begin
         half_ff <= half_in;
      end
      if (stage_en[3]) begin
         band_ff <= band_in;
      end
   end

   assign band = band_ff;

endmodule

@@ rtl/core/mwd_pipe.sv @@
`timescale 1ns / 1ps

module mwd_pipe (
   input  logic                        clock,
   input  logic                        reset,
   mwd_req_if.sink                     req_if,
   input  logic [mwd_pkg::UG_W-1:0]    initial_ug,
   input  logic [mwd_pkg::UG_W-1:0]    continue_ug,
   output logic                        out_valid,
   input  logic                        out_ready,
   output mwd_pkg::item_type           out_item,
   output mwd_pkg::band_pair_type      out_bands
);
   import mwd_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff, valid_in;
   logic [STAGES-1:0] free;
   item_type          item_ff [STAGES];
   item_type          req_item;

   always_comb begin
      req_item.op        = op_type'(req_if.op);
      req_item.magnitude = req_if.magnitude;
      req_item.one_g     = req_if.one_g_count;
      req_item.last      = req_if.last_in_batch;

      // a stage may load when empty or when its word moves on
      free[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         free[k] = !valid_ff[k] || free[k+1];
      end

      valid_in[0] = free[0] ? req_if.valid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         valid_in[k] = free[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free[0]) begin
         item_ff[0] <= req_item;
      end
      for (int k = 1; k < STAGES; k++) begin
         if (free[k]) begin
            item_ff[k] <= item_ff[k-1];
         end
      end
   end

   mwd_band_calc u_init_band (
      .clock        (clock),
      .stage_en     (free[4:1]),
      .threshold_ug (initial_ug),
      .one_g_s0     (item_ff[0].one_g),
      .one_g_s3     (item_ff[3].one_g),
      .band         (out_bands.init)
   );

   mwd_band_calc u_cont_band (
      .clock        (clock),
      .stage_en     (free[4:1]),
      .threshold_ug (continue_ug),
      .one_g_s0     (item_ff[0].one_g),
      .one_g_s3     (item_ff[3].one_g),
      .band         (out_bands.cont)
   );

   assign req_if.ready = free[0];
   assign out_valid    = valid_ff[STAGES-1];
   assign out_item     = item_ff[STAGES-1];

endmodule

@@ rtl/core/mwd_track.sv @@
`timescale 1ns / 1ps

module mwd_track (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  mwd_pkg::item_type           in_item,
   input  mwd_pkg::band_pair_type      in_bands,
   input  logic [mwd_pkg::TICK_W-1:0]  hold_ticks,
   mwd_rsp_if.source                   rsp_if
);
   import mwd_pkg::*;

   logic [ONE_G_W-1:0] cached_one_g_ff, cached_one_g_in;
   band_pair_type      bands_ff, bands_in;
   logic               batch_hit_ff, batch_hit_in;
   logic [TICK_W-1:0]  hold_left_ff, hold_left_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               moving_ff, moving_in;
   logic               started_ff, started_in;
   logic               oob_ff, oob_in;

   logic               out_free;
   logic               has_result;
   logic               take;
   logic               moving_now;
   logic               recompute;
   band_pair_type      use_bands;
   band_type           sel;
   logic               outside;
   logic               hit;
   logic [TICK_W-1:0]  hold_load;

   always_comb begin
      out_free   = !rsp_valid_ff || rsp_if.ready;
      has_result = (in_item.op == OP_TICK) || in_item.last;
      in_ready   = !has_result || out_free;
      take       = in_valid && in_ready;

      moving_now = hold_left_ff != '0;
      recompute  = in_item.one_g != cached_one_g_ff;
      use_bands  = recompute ? in_bands : bands_ff;
      sel        = moving_now ? use_bands.cont : use_bands.init;
      outside    = ({1'b0, sel.lo} > in_item.magnitude) ||
                   (BAND_W'(in_item.magnitude) > sel.hi);
      hit        = batch_hit_ff || outside;
      hold_load  = (hold_ticks == '0) ? TICK_W'(1) : hold_ticks;

      cached_one_g_in = cached_one_g_ff;
      bands_in        = bands_ff;
      batch_hit_in    = batch_hit_ff;
      hold_left_in    = hold_left_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_if.ready;
      started_in      = 1'b0;
      oob_in          = 1'b0;

      if (take) begin
         if (in_item.op == OP_TICK) begin
            if (moving_now) begin
               hold_left_in = hold_left_ff - TICK_W'(1);
            end
         end else begin
            if (recompute) begin
               cached_one_g_in = in_item.one_g;
               bands_in        = in_bands;
            end
            if (in_item.last) begin
               batch_hit_in = 1'b0;
               oob_in       = hit;
               if (hit) begin
                  started_in   = !moving_now;
                  hold_left_in = hold_load;
               end
            end else begin
               batch_hit_in = hit;
            end
         end
         if (has_result) begin
            rsp_valid_in = 1'b1;
         end
      end
      moving_in = hold_left_in != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cached_one_g_ff <= '0;
         bands_ff        <= '0;
         batch_hit_ff    <= 1'b0;
         hold_left_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         cached_one_g_ff <= cached_one_g_in;
         bands_ff        <= bands_in;
         batch_hit_ff    <= batch_hit_in;
         hold_left_ff    <= hold_left_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && has_result) begin
         moving_ff  <= moving_in;
         started_ff <= started_in;
         oob_ff     <= oob_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.moving         = moving_ff;
   assign rsp_if.started_moving = started_ff;
   assign rsp_if.out_of_band    = oob_ff;

endmodule

@@ rtl/core/movement_window_detector.sv @@
`timescale 1ns / 1ps

// Movement detector: window comparator with hysteresis on acceleration magnitude.
// req_if carries one word per sample (op = 0) or per time tick (op = 1). A sample
// brings its magnitude, the raw count for 1 g and a last-in-batch mark. rsp_if
// returns one word per last sample of a batch and one per tick: moving,
// started_moving and out_of_band. Other samples give no word.
// Bands around 1 g are rebuilt whenever one_g_count differs from the cached value;
// a threshold write alone does not rebuild them.
// From the accepting edge to rsp_if.valid a word passes through four band
// stages (multiply, reciprocal partial products, sum, band edges) and the state
// and result register. Throughput: one word per cycle without back-pressure.
// The csr_ port writes a register at any edge with csr_we high; write only
// while the block is idle. Reset clears the pipeline, the band cache and the
// moving countdown, and restores the register defaults.
// When rsp_if.ready is low, the result register holds and the pipeline keeps
// accepting until its stages fill, then req_if.ready drops.

module movement_window_detector (
   input  logic                          clock,
   input  logic                          reset,
   mwd_req_if.sink                       req_if,
   mwd_rsp_if.source                     rsp_if,
   input  logic                          csr_we,
   input  logic [mwd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [mwd_pkg::UG_W-1:0]      csr_wdata
);
   import mwd_pkg::*;

   logic [UG_W-1:0]   initial_ug_ff, initial_ug_in;
   logic [UG_W-1:0]   continue_ug_ff, continue_ug_in;
   logic [TICK_W-1:0] hold_ticks_ff, hold_ticks_in;

   logic              mid_valid;
   logic              mid_ready;
   item_type          mid_item;
   band_pair_type     mid_bands;

   always_comb begin
      initial_ug_in  = initial_ug_ff;
      continue_ug_in = continue_ug_ff;
      hold_ticks_in  = hold_ticks_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_INITIAL_UG:  initial_ug_in  = csr_wdata;
            CSR_CONTINUE_UG: continue_ug_in = csr_wdata;
            CSR_HOLD_TICKS:  hold_ticks_in  = csr_wdata[TICK_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_ug_ff  <= INITIAL_UG_RST;
         continue_ug_ff <= CONTINUE_UG_RST;
         hold_ticks_ff  <= HOLD_TICKS_RST;
      end else begin
         initial_ug_ff  <= initial_ug_in;
         continue_ug_ff <= continue_ug_in;
         hold_ticks_ff  <= hold_ticks_in;
      end
   end

   mwd_pipe u_pipe (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .initial_ug  (initial_ug_ff),
      .continue_ug (continue_ug_ff),
      .out_valid   (mid_valid),
      .out_ready   (mid_ready),
      .out_item    (mid_item),
      .out_bands   (mid_bands)
   );

   mwd_track u_track (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_valid),
      .in_ready   (mid_ready),
      .in_item    (mid_item),
      .in_bands   (mid_bands),
      .hold_ticks (hold_ticks_ff),
      .rsp_if     (rsp_if)
   );

endmodule
